// ===== hw/rtl/rsc_pkg.sv =====
// Shared constants and types for the range sum counter.
`timescale 1ns / 1ps

package rsc_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int FILL_W    = $clog2(MAX_ITEMS + 1);
  localparam int VALUE_W   = 32;
  localparam int PREFIX_W  = VALUE_W + FILL_W - 1;
  localparam int DIFF_W    = PREFIX_W + 1;
  localparam int TOTAL_W   = 20;
  localparam int CFG_IDX_W = 8;

  localparam logic [TOTAL_W-1:0]   TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [CFG_IDX_W-1:0] REG_LOWER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = CFG_IDX_W'(1);

  typedef struct packed {
    logic                       en;
    logic [ADDR_W-1:0]          addr;
    logic signed [PREFIX_W-1:0] data;
  } rsc_wr_t;

endpackage

// ===== hw/rtl/rsc_prefix_store.sv =====
// Storage for earlier prefix sums, one write port and one registered read port.
`timescale 1ns / 1ps

module rsc_prefix_store
  import rsc_pkg::*;
(
  input  logic                       clk,
  input  rsc_wr_t                    wr,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic signed [PREFIX_W-1:0] rd_data
);

  logic signed [PREFIX_W-1:0] mem [MAX_ITEMS];
  logic signed [PREFIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/rsc_range_check.sv =====
// Shared difference and limit compare unit.
`timescale 1ns / 1ps

module rsc_range_check
  import rsc_pkg::*;
(
  input  logic signed [PREFIX_W-1:0] prefix,
  input  logic signed [PREFIX_W-1:0] operand,
  input  logic signed [VALUE_W-1:0]  lower,
  input  logic signed [VALUE_W-1:0]  upper,
  output logic                       hit
);

  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] lower_ext;
  logic signed [DIFF_W-1:0] upper_ext;

  // The difference of two prefix sums needs one extra bit.
  assign diff      = DIFF_W'(prefix) - DIFF_W'(operand);
  assign lower_ext = DIFF_W'(lower);
  assign upper_ext = DIFF_W'(upper);
  assign hit       = (diff >= lower_ext) && (diff <= upper_ext);

endmodule

// ===== hw/rtl/range_sum_counter.sv =====
// Top level of the range sum counter: sequencer, registers and result output.
`timescale 1ns / 1ps

// Channel   Ports                               Direction  Handshake
// input     start, busy, in_value, in_last      in / out   start & !busy
// result    out_valid, out_count, out_overflow  out        one-cycle strobe
// config    cfg_valid, cfg_ready, cfg_index,    in / out   cfg_valid & cfg_ready
//           cfg_data
//
// An accepted word is compared against the empty prefix, then against each
// stored prefix sum, walking the prefix store with one read and one compare
// per cycle. A word that arrives once the store is full is dropped and only
// sets the overflow flag, though a last word still closes the sequence.
// Reset (synchronous, active low) clears the sequence state and both limits;
// the store itself is never cleared since only written entries are read.
// The result strobe lasts one cycle and the receiver cannot stall it.

module range_sum_counter
  import rsc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [VALUE_W-1:0]  in_value,
  input  logic                       in_last,
  output logic                       out_valid,
  output logic [TOTAL_W-1:0]         out_count,
  output logic                       out_overflow,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic signed [VALUE_W-1:0]  cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ZERO   = 4'b0010,
    ST_WALK   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t                     state_r, state_nxt;
  logic signed [VALUE_W-1:0]  lower_r, upper_r;
  logic signed [PREFIX_W-1:0] running_r, running_nxt;
  logic signed [PREFIX_W-1:0] prefix_r, prefix_nxt;
  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic [TOTAL_W-1:0]         total_r, total_nxt;
  logic                       dropped_r, dropped_nxt;
  logic                       last_r, last_nxt;
  logic [ADDR_W-1:0]          idx_r, idx_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [TOTAL_W-1:0]         out_count_r, out_count_nxt;
  logic                       out_overflow_r, out_overflow_nxt;

  rsc_wr_t                    wr;
  logic [ADDR_W-1:0]          rd_addr;
  logic signed [PREFIX_W-1:0] rd_data;
  logic signed [PREFIX_W-1:0] operand;
  logic                       hit;
  logic                       accept;
  logic                       walk_done;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // The compare unit sees the empty prefix first, then each stored prefix.
  assign operand   = (state_r == ST_ZERO) ? '0 : rd_data;
  assign walk_done = (FILL_W'(idx_r) + FILL_W'(1)) == fill_r;

  rsc_prefix_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rsc_range_check u_check (
    .prefix  (prefix_r),
    .operand (operand),
    .lower   (lower_r),
    .upper   (upper_r),
    .hit     (hit)
  );

  always_comb begin
    state_nxt        = state_r;
    running_nxt      = running_r;
    prefix_nxt       = prefix_r;
    fill_nxt         = fill_r;
    total_nxt        = total_r;
    dropped_nxt      = dropped_r;
    last_nxt         = last_r;
    idx_nxt          = idx_r;
    out_valid_nxt    = 1'b0;
    out_count_nxt    = out_count_r;
    out_overflow_nxt = out_overflow_r;
    wr.en            = 1'b0;
    wr.addr          = fill_r[ADDR_W-1:0];
    wr.data          = prefix_r;
    rd_addr          = idx_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (fill_r < FILL_W'(MAX_ITEMS)) begin
            prefix_nxt = running_r + PREFIX_W'(in_value);
            last_nxt   = in_last;
            idx_nxt    = '0;
            state_nxt  = ST_ZERO;
          end else begin
            // Store is full: the word is dropped, but a last word still
            // closes the sequence.
            dropped_nxt = 1'b1;
            if (in_last) begin
              out_valid_nxt    = 1'b1;
              out_count_nxt    = total_r;
              out_overflow_nxt = 1'b1;
              running_nxt      = '0;
              fill_nxt         = '0;
              total_nxt        = '0;
              dropped_nxt      = 1'b0;
            end
          end
        end
      end
      ST_ZERO: begin
        // Compare against the empty prefix, store the new prefix, and start
        // the read of the first stored entry.
        if (hit && (total_r < TOTAL_MAX)) begin
          total_nxt = total_r + TOTAL_W'(1);
        end
        wr.en     = 1'b1;
        rd_addr   = '0;
        state_nxt = (fill_r == '0) ? ST_FINISH : ST_WALK;
      end
      ST_WALK: begin
        if (hit && (total_r < TOTAL_MAX)) begin
          total_nxt = total_r + TOTAL_W'(1);
        end
        rd_addr = idx_r + ADDR_W'(1);
        idx_nxt = idx_r + ADDR_W'(1);
        if (walk_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        fill_nxt    = fill_r + FILL_W'(1);
        running_nxt = prefix_r;
        state_nxt   = ST_IDLE;
        if (last_r) begin
          out_valid_nxt    = 1'b1;
          out_count_nxt    = total_r;
          out_overflow_nxt = dropped_r;
          running_nxt      = '0;
          fill_nxt         = '0;
          total_nxt        = '0;
          dropped_nxt      = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      running_r   <= '0;
      fill_r      <= '0;
      total_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      lower_r     <= '0;
      upper_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
      // Writes to an index beyond the two limits are ignored.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_LOWER) begin
          lower_r <= cfg_data;
        end else if (cfg_index == REG_UPPER) begin
          upper_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prefix_r       <= prefix_nxt;
    last_r         <= last_nxt;
    idx_r          <= idx_nxt;
    out_count_r    <= out_count_nxt;
    out_overflow_r <= out_overflow_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_count    = out_count_r;
  assign out_overflow = out_overflow_r;

endmodule
